### hdl/bcs_pkg.sv
// Package: shared types and constants of the bake cycle sequencer.
package bcs_pkg;

  localparam int unsigned DebounceW = 8;
  localparam int unsigned TpsW      = 10;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned SecCntW   = 16;
  localparam int unsigned RemW      = 14;
  localparam int unsigned MinShownW = 8;

  localparam logic [6:0] KneadMax = 7'd99;
  localparam logic [7:0] RiseMax  = 8'd180;
  localparam logic [6:0] BakeMax  = 7'd99;
  localparam logic [RemW-1:0] SecsPerMin = RemW'(60);

  localparam logic [DebounceW-1:0] DebounceReset = DebounceW'(10);
  localparam logic [TpsW-1:0]      TpsReset      = TpsW'(1000);

  typedef enum logic [0:0] {
    CFG_DEBOUNCE_TICKS   = 1'b0,
    CFG_TICKS_PER_SECOND = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_SET_KNEAD = 3'd0,
    PH_SET_RISE  = 3'd1,
    PH_SET_BAKE  = 3'd2,
    PH_RUN_KNEAD = 3'd3,
    PH_RUN_RISE  = 3'd4,
    PH_RUN_BAKE  = 3'd5,
    PH_DONE      = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KEY_NONE   = 2'd0,
    KEY_SELECT = 2'd1,
    KEY_UP     = 2'd2,
    KEY_DOWN   = 2'd3
  } key_e;

  // phase status seen by the button logic
  typedef struct packed {
    logic running;
    logic in_set;
  } bcs_status_t;

  // button logic decision for the current tick
  typedef struct packed {
    logic ignore;
    key_e key;
  } bcs_press_t;

  typedef struct packed {
    logic [2:0]           phase;
    logic                 motor_on;
    logic                 heater_on;
    logic                 beep_start;
    logic [RemW-1:0]      seconds_left;
    logic [MinShownW-1:0] minutes_shown;
  } bcs_result_t;

endpackage

### hdl/bcs_in_if.sv
// Interface: input tick channel carrying the three button levels.
interface bcs_in_if;
  logic valid;
  logic ready;
  logic select_pressed;
  logic up_pressed;
  logic down_pressed;

  modport source (output valid, output select_pressed, output up_pressed,
                  output down_pressed, input ready);
  modport sink   (input valid, input select_pressed, input up_pressed,
                  input down_pressed, output ready);
endinterface

### hdl/bcs_out_if.sv
// Interface: result channel of the bake cycle sequencer.
interface bcs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  phase;
  logic        motor_on;
  logic        heater_on;
  logic        beep_start;
  logic [13:0] seconds_left;
  logic [7:0]  minutes_shown;

  modport source (output valid, output phase, output motor_on, output heater_on,
                  output beep_start, output seconds_left, output minutes_shown,
                  input ready);
  modport sink   (input valid, input phase, input motor_on, input heater_on,
                  input beep_start, input seconds_left, input minutes_shown,
                  output ready);
endinterface

### hdl/bcs_press_ctrl.sv
// Button press qualification: debounce, release tracking, select-hold filter.
module bcs_press_ctrl
  import bcs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 sel_i,
  input  logic                 up_i,
  input  logic                 down_i,
  input  logic [DebounceW-1:0] debounce_ticks_i,
  input  bcs_status_t          status_i,
  output bcs_press_t           press_o
);

  logic [DebounceW-1:0] debounce_left_q, debounce_left_d, debounce_dec;
  logic                 press_handled_q, press_handled_d, handled_cur;
  logic                 wait_rel_q, wait_rel_d;
  logic                 none_held, take;
  key_e                 key;

  always_comb begin
    none_held    = !sel_i && !up_i && !down_i;
    debounce_dec = (debounce_left_q != '0) ? debounce_left_q - 1'b1 : debounce_left_q;
    handled_cur  = press_handled_q && !none_held;
    take         = !status_i.running && (debounce_dec == '0) && !handled_cur;
    key          = KEY_NONE;
    if (take) begin
      if (sel_i)       key = KEY_SELECT;
      else if (up_i)   key = KEY_UP;
      else if (down_i) key = KEY_DOWN;
    end
    press_o.ignore = wait_rel_q && sel_i;
    press_o.key    = key;
  end

  always_comb begin
    debounce_left_d = debounce_left_q;
    press_handled_d = press_handled_q;
    wait_rel_d      = wait_rel_q;
    if (step_i && !press_o.ignore) begin
      debounce_left_d = debounce_dec;
      press_handled_d = handled_cur;
      wait_rel_d      = 1'b0;
      if (key != KEY_NONE) begin
        debounce_left_d = debounce_ticks_i;
        press_handled_d = 1'b1;
      end
      // leaving a set phase restarts press tracking and waits for select release
      if (key == KEY_SELECT && status_i.in_set) begin
        debounce_left_d = '0;
        press_handled_d = 1'b0;
        wait_rel_d      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_left_q <= '0;
      press_handled_q <= 1'b0;
      wait_rel_q      <= 1'b0;
    end else begin
      debounce_left_q <= debounce_left_d;
      press_handled_q <= press_handled_d;
      wait_rel_q      <= wait_rel_d;
    end
  end

endmodule

### hdl/bcs_tick_div.sv
// Tick divider: counts running ticks and flags each completed second.
module bcs_tick_div
  import bcs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            running_i,
  input  logic [TpsW-1:0] ticks_per_second_i,
  output logic            sec_inc_o
);

  logic [TpsW-1:0] tick_count_q, tick_count_d, tick_next;

  always_comb begin
    tick_next    = tick_count_q + 1'b1;
    sec_inc_o    = running_i && (tick_next >= ticks_per_second_i);
    tick_count_d = tick_count_q;
    if (step_i) begin
      if (!running_i || sec_inc_o) tick_count_d = '0;
      else                         tick_count_d = tick_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tick_count_q <= '0;
    else         tick_count_q <= tick_count_d;
  end

endmodule

### hdl/bcs_phase_fsm.sv
// Phase machine: minute settings, countdown, motor/heater drive and result fields.
module bcs_phase_fsm
  import bcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        sec_inc_i,
  input  key_e        key_i,
  output bcs_status_t status_o,
  output bcs_result_t result_o
);

  phase_e               phase_q, phase_d;
  logic [6:0]           knead_q, knead_d;
  logic [7:0]           rise_q, rise_d;
  logic [6:0]           bake_q, bake_d;
  logic [SecCntW-1:0]   sec_cnt_q, sec_cnt_d, sec_now;
  logic [SecCntW-1:0]   last_sec_q, last_sec_d;
  logic [RemW-1:0]      rem_q, rem_d;
  logic                 motor_q, motor_d;
  logic                 heater_q, heater_d;
  logic                 beep;
  logic                 new_sec, run_d;

  always_comb begin
    status_o.running = (phase_q == PH_RUN_KNEAD) || (phase_q == PH_RUN_RISE) ||
                       (phase_q == PH_RUN_BAKE);
    status_o.in_set  = (phase_q == PH_SET_KNEAD) || (phase_q == PH_SET_RISE) ||
                       (phase_q == PH_SET_BAKE);
  end

  always_comb begin
    phase_d    = phase_q;
    knead_d    = knead_q;
    rise_d     = rise_q;
    bake_d     = bake_q;
    sec_now    = sec_cnt_q + SecCntW'(sec_inc_i);
    sec_cnt_d  = sec_cnt_q;
    last_sec_d = last_sec_q;
    rem_d      = rem_q;
    motor_d    = motor_q;
    heater_d   = heater_q;
    beep       = 1'b0;
    new_sec    = sec_now != last_sec_q;
    if (step_i) begin
      sec_cnt_d = sec_now;
      case (phase_q)
        PH_SET_KNEAD: begin
          if (key_i == KEY_UP && knead_q < KneadMax)   knead_d = knead_q + 1'b1;
          else if (key_i == KEY_DOWN && knead_q > 7'd1) knead_d = knead_q - 1'b1;
          if (key_i == KEY_SELECT) phase_d = PH_SET_RISE;
        end
        PH_SET_RISE: begin
          if (key_i == KEY_UP && rise_q < RiseMax)     rise_d = rise_q + 1'b1;
          else if (key_i == KEY_DOWN && rise_q > 8'd1) rise_d = rise_q - 1'b1;
          if (key_i == KEY_SELECT) phase_d = PH_SET_BAKE;
        end
        PH_SET_BAKE: begin
          if (key_i == KEY_UP && bake_q < BakeMax)     bake_d = bake_q + 1'b1;
          else if (key_i == KEY_DOWN && bake_q > 7'd1) bake_d = bake_q - 1'b1;
          if (key_i == KEY_SELECT) begin
            phase_d   = PH_RUN_KNEAD;
            rem_d     = RemW'(knead_q) * SecsPerMin;
            sec_cnt_d = '0;
            motor_d   = 1'b1;
          end
        end
        PH_RUN_KNEAD, PH_RUN_RISE, PH_RUN_BAKE: begin
          if (new_sec) begin
            last_sec_d = sec_now;
            if (rem_q != '0) begin
              rem_d = rem_q - 1'b1;
            end else begin
              case (phase_q)
                PH_RUN_KNEAD: begin
                  motor_d   = 1'b0;
                  phase_d   = PH_RUN_RISE;
                  rem_d     = RemW'(rise_q) * SecsPerMin;
                  sec_cnt_d = '0;
                end
                PH_RUN_RISE: begin
                  heater_d  = 1'b1;
                  phase_d   = PH_RUN_BAKE;
                  rem_d     = RemW'(bake_q) * SecsPerMin;
                  sec_cnt_d = '0;
                end
                default: begin
                  heater_d = 1'b0;
                  phase_d  = PH_DONE;
                  beep     = 1'b1;
                end
              endcase
            end
          end
        end
        PH_DONE: begin
          if (key_i == KEY_SELECT) phase_d = PH_SET_KNEAD;
        end
        default: ;
      endcase
    end
  end

  // result fields reflect the state after this tick
  always_comb begin
    run_d = (phase_d == PH_RUN_KNEAD) || (phase_d == PH_RUN_RISE) ||
            (phase_d == PH_RUN_BAKE);
    result_o.phase        = phase_d;
    result_o.motor_on     = motor_d;
    result_o.heater_on    = heater_d;
    result_o.beep_start   = beep;
    result_o.seconds_left = run_d ? rem_d : '0;
    case (phase_d)
      PH_SET_KNEAD: result_o.minutes_shown = MinShownW'(knead_d);
      PH_SET_RISE:  result_o.minutes_shown = rise_d;
      PH_SET_BAKE:  result_o.minutes_shown = MinShownW'(bake_d);
      default:      result_o.minutes_shown = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SET_KNEAD;
      knead_q    <= 7'd1;
      rise_q     <= 8'd1;
      bake_q     <= 7'd1;
      sec_cnt_q  <= '0;
      last_sec_q <= '0;
      rem_q      <= '0;
      motor_q    <= 1'b0;
      heater_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      knead_q    <= knead_d;
      rise_q     <= rise_d;
      bake_q     <= bake_d;
      sec_cnt_q  <= sec_cnt_d;
      last_sec_q <= last_sec_d;
      rem_q      <= rem_d;
      motor_q    <= motor_d;
      heater_q   <= heater_d;
    end
  end

endmodule

### hdl/bake_cycle_sequencer_core.sv
// Top level: bake cycle sequencer with config registers and result register.
// The result is registered: it shows on out_o in the cycle after the input transfer.
// Throughput: one tick per cycle; the single result register is refilled in the
//   same cycle it is drained, so input ready only drops while a result stalls.
// Reset: rst_ni is asynchronous, active low; phase returns to set knead, all
//   minutes to 1, counters clear, debounce_ticks to 10, ticks_per_second to 1000.
module bake_cycle_sequencer_core
  import bcs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  bcs_in_if.sink              in_i,
  bcs_out_if.source           out_o
);

  // configuration registers
  logic [DebounceW-1:0] debounce_ticks_q;
  logic [TpsW-1:0]      tps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= DebounceReset;
      tps_q            <= TpsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEBOUNCE_TICKS:   debounce_ticks_q <= cfg_data_i[DebounceW-1:0];
        CFG_TICKS_PER_SECOND: tps_q            <= cfg_data_i[TpsW-1:0];
        default: ;
      endcase
    end
  end

  // handshake: take a tick whenever the result register is free or draining
  logic step, adv;
  assign in_i.ready = !out_o.valid || out_o.ready;
  assign step       = in_i.valid && in_i.ready;

  bcs_status_t status;
  bcs_press_t  press;
  bcs_result_t result;
  logic        sec_inc;

  // a tick with select still held after an advance leaves the press, divider and phase state untouched
  assign adv = step && !press.ignore;

  bcs_press_ctrl u_press (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .sel_i            (in_i.select_pressed),
    .up_i             (in_i.up_pressed),
    .down_i           (in_i.down_pressed),
    .debounce_ticks_i (debounce_ticks_q),
    .status_i         (status),
    .press_o          (press)
  );

  bcs_tick_div u_tick (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (adv),
    .running_i          (status.running),
    .ticks_per_second_i (tps_q),
    .sec_inc_o          (sec_inc)
  );

  bcs_phase_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .sec_inc_i (sec_inc),
    .key_i     (press.key),
    .status_o  (status),
    .result_o  (result)
  );

  // result register
  logic        out_valid_q, out_valid_d;
  bcs_result_t res_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (step)              out_valid_d = 1'b1;
    else if (out_o.ready)  out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= result;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.phase         = res_q.phase;
  assign out_o.motor_on      = res_q.motor_on;
  assign out_o.heater_on     = res_q.heater_on;
  assign out_o.beep_start    = res_q.beep_start;
  assign out_o.seconds_left  = res_q.seconds_left;
  assign out_o.minutes_shown = res_q.minutes_shown;

endmodule

### hdl/bcs_checker.sv
// Checker: port-level properties of the bake cycle sequencer, bound to the top.
module bcs_checker
  import bcs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  phase_i,
  input logic        motor_on_i,
  input logic        heater_on_i,
  input logic        beep_start_i,
  input logic [13:0] seconds_left_i,
  input logic [7:0]  minutes_shown_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(phase_i) &&
      $stable(seconds_left_i))
    else $error("result changed while stalled");

  a_motor_knead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && motor_on_i |-> phase_i == PH_RUN_KNEAD)
    else $error("motor on outside knead run");

  a_heater_bake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && heater_on_i |-> phase_i == PH_RUN_BAKE)
    else $error("heater on outside bake run");

  a_beep_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && beep_start_i |-> phase_i == PH_DONE && !heater_on_i && !motor_on_i)
    else $error("beep without bake finish");

  a_display: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (minutes_shown_i != '0) |-> seconds_left_i == '0 &&
      (phase_i == PH_SET_KNEAD || phase_i == PH_SET_RISE || phase_i == PH_SET_BAKE))
    else $error("minutes shown outside set phases");

endmodule

bind bake_cycle_sequencer_core bcs_checker u_bcs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .phase_i         (out_o.phase),
  .motor_on_i      (out_o.motor_on),
  .heater_on_i     (out_o.heater_on),
  .beep_start_i    (out_o.beep_start),
  .seconds_left_i  (out_o.seconds_left),
  .minutes_shown_i (out_o.minutes_shown)
);
